// File: src/ttci_pkg.sv
// Package with the command types, control codes and constants of the terminal interpreter.
`timescale 1ns / 1ps

package ttci_pkg;

    typedef enum logic [2:0] {
        OP_CHAR        = 3'd0,
        OP_CURSOR      = 3'd1,
        OP_SCROLL_UP   = 3'd2,
        OP_SCROLL_DOWN = 3'd3,
        OP_SHAPE       = 3'd4,
        OP_BELL        = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_ROW  = 2'd1,
        ESC_COL  = 2'd2
    } t_esc;

    typedef enum logic [0:0] {
        CFG_MAX_COLUMN    = 1'b0,
        CFG_COLOR_DISPLAY = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [6:0] max_column;
        logic       color_display;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [7:0]  char_code;
        logic [7:0]  attribute;
        logic [4:0]  row;
        logic [6:0]  col;
        logic [4:0]  bottom_row;
        logic [6:0]  right_col;
        logic        line_count;
        logic [15:0] cursor_shape;
    } t_cmd;

    // Up to two commands produced by one byte, in issue order.
    typedef struct packed {
        logic [1:0] count;
        t_cmd       cmd0;
        t_cmd       cmd1;
    } t_dec;

    localparam logic [7:0] CODE_ERASE_EOL    = 8'd1;
    localparam logic [7:0] CODE_ERASE_EOS    = 8'd2;
    localparam logic [7:0] CODE_INSERT_LINE  = 8'd3;
    localparam logic [7:0] CODE_ATTR_BLUE    = 8'd4;
    localparam logic [7:0] CODE_ATTR_NORMAL  = 8'd5;
    localparam logic [7:0] CODE_DELETE_LINE  = 8'd6;
    localparam logic [7:0] CODE_BELL         = 8'd7;
    localparam logic [7:0] CODE_BACKSPACE    = 8'd8;
    localparam logic [7:0] CODE_TAB          = 8'd9;
    localparam logic [7:0] CODE_LINE_FEED    = 8'd10;
    localparam logic [7:0] CODE_BRIGHT_ON    = 8'd11;
    localparam logic [7:0] CODE_BRIGHT_OFF   = 8'd12;
    localparam logic [7:0] CODE_RETURN       = 8'd13;
    localparam logic [7:0] CODE_ATTR_PLAIN   = 8'd14;
    localparam logic [7:0] CODE_BLINK_OFF    = 8'd15;
    localparam logic [7:0] CODE_REVERSE      = 8'd16;
    localparam logic [7:0] CODE_BLINK_ON     = 8'd17;
    localparam logic [7:0] CODE_ADDRESS      = 8'd18;
    localparam logic [7:0] CODE_SHAPE_ALT    = 8'd19;
    localparam logic [7:0] CODE_SHAPE_NORMAL = 8'd20;
    localparam logic [7:0] CODE_SPACE        = 8'd32;
    localparam logic [7:0] ADDR_OFFSET       = 8'd32;

    localparam logic [7:0] ATTR_RESET      = 8'h07;
    localparam logic [7:0] ATTR_KEEP_MASK  = 8'h88;
    localparam logic [7:0] ATTR_BLUE       = 8'h01;
    localparam logic [7:0] ATTR_WHITE      = 8'h07;
    localparam logic [7:0] ATTR_REVERSE    = 8'h70;
    localparam logic [7:0] ATTR_BRIGHT     = 8'h08;
    localparam logic [7:0] ATTR_NOT_BRIGHT = 8'hF7;
    localparam logic [7:0] ATTR_BLINK      = 8'h80;
    localparam logic [7:0] ATTR_NOT_BLINK  = 8'h7F;

    localparam logic [15:0] SHAPE_MONO_NORMAL  = 16'h0c0d;
    localparam logic [15:0] SHAPE_MONO_ALT     = 16'h060d;
    localparam logic [15:0] SHAPE_COLOR_NORMAL = 16'h0607;
    localparam logic [15:0] SHAPE_COLOR_ALT    = 16'h0307;

    localparam logic [6:0] MAX_COLUMN_RESET = 7'd79;
    localparam logic [6:0] COL_LIMIT        = 7'd127;

    function automatic t_cmd f_cursor(input logic [4:0] row, input logic [6:0] col);
        t_cmd c;
        c = '0;
        c.op = OP_CURSOR;
        c.row = row;
        c.col = col;
        return c;
    endfunction

    function automatic t_cmd f_window(input t_op op, input logic [7:0] attr,
                                      input logic [4:0] top, input logic [6:0] left,
                                      input logic [4:0] bottom, input logic [6:0] right,
                                      input logic lines);
        t_cmd c;
        c = '0;
        c.op = op;
        c.attribute = attr;
        c.row = top;
        c.col = left;
        c.bottom_row = bottom;
        c.right_col = right;
        c.line_count = lines;
        return c;
    endfunction

endpackage

// File: src/ttci_decode.sv
// Combinational decoder: one byte and the terminal state give the commands and the next state.
`timescale 1ns / 1ps

module ttci_decode #(
    parameter int LAST_ROW = 24,
    parameter int ROW_W    = 5
) (
    input  logic [7:0]        i_code,
    input  ttci_pkg::t_cfg    i_cfg,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [6:0]        i_col,
    input  logic [7:0]        i_attr,
    input  ttci_pkg::t_esc    i_esc,
    input  logic [7:0]        i_pending,
    output logic [ROW_W-1:0]  o_row,
    output logic [6:0]        o_col,
    output logic [7:0]        o_attr,
    output ttci_pkg::t_esc    o_esc,
    output logic [7:0]        o_pending,
    output ttci_pkg::t_dec    o_dec
);

    localparam logic [ROW_W-1:0] LastRow  = ROW_W'(LAST_ROW);
    localparam logic [4:0]       LastRow5 = 5'(LAST_ROW);

    logic [7:0]       w_col_off;
    logic [7:0]       w_row_off;
    logic [6:0]       w_addr_col;
    logic [ROW_W-1:0] w_addr_row;
    logic [4:0]       w_row5;
    logic [4:0]       w_row5_next;
    logic             w_row_below;
    logic             w_printable;
    logic [6:0]       w_col_inc;

    // Saturated cursor address from the two offset bytes.
    assign w_col_off  = i_code - ttci_pkg::ADDR_OFFSET;
    assign w_row_off  = i_pending - ttci_pkg::ADDR_OFFSET;
    assign w_addr_col = (i_code < ttci_pkg::ADDR_OFFSET) ? 7'd0 :
                        (w_col_off > {1'b0, i_cfg.max_column}) ? i_cfg.max_column :
                        w_col_off[6:0];
    assign w_addr_row = (i_pending < ttci_pkg::ADDR_OFFSET) ? '0 :
                        (w_row_off > 8'(LAST_ROW)) ? LastRow : ROW_W'(w_row_off);

    assign w_row5      = 5'(i_row);
    assign w_row5_next = 5'(i_row + 1'b1);
    assign w_row_below = (i_row < LastRow);
    assign w_printable = (i_code == 8'd0) || (i_code > ttci_pkg::CODE_SHAPE_NORMAL);
    assign w_col_inc   = (i_col < ttci_pkg::COL_LIMIT) ? i_col + 7'd1 : i_col;

    always_comb begin
        o_row     = i_row;
        o_col     = i_col;
        o_attr    = i_attr;
        o_esc     = i_esc;
        o_pending = i_pending;
        o_dec     = '0;

        if (i_esc == ttci_pkg::ESC_ROW) begin
            o_pending = i_code;
            o_esc     = ttci_pkg::ESC_COL;
        end else if (i_esc == ttci_pkg::ESC_COL) begin
            o_col      = w_addr_col;
            o_row      = w_addr_row;
            o_esc      = ttci_pkg::ESC_IDLE;
            o_dec.count = 2'd1;
            o_dec.cmd0 = ttci_pkg::f_cursor(5'(w_addr_row), w_addr_col);
        end else if (w_printable || i_code == ttci_pkg::CODE_TAB) begin
            // A byte at a column past the margin is dropped.
            if (i_col <= i_cfg.max_column) begin
                o_col       = w_col_inc;
                o_dec.count = 2'd2;
                o_dec.cmd0  = '0;
                o_dec.cmd0.op        = ttci_pkg::OP_CHAR;
                o_dec.cmd0.char_code = w_printable ? i_code : ttci_pkg::CODE_SPACE;
                o_dec.cmd0.attribute = i_attr;
                o_dec.cmd0.row       = w_row5;
                o_dec.cmd0.col       = i_col;
                o_dec.cmd1 = ttci_pkg::f_cursor(w_row5, w_col_inc);
            end
        end else begin
            case (i_code)
                ttci_pkg::CODE_ERASE_EOL: begin
                    o_dec.count = 2'd1;
                    o_dec.cmd0 = ttci_pkg::f_window(ttci_pkg::OP_SCROLL_UP, i_attr, w_row5,
                                                    i_col, w_row5, i_cfg.max_column, 1'b0);
                end
                ttci_pkg::CODE_ERASE_EOS: begin
                    o_dec.count = w_row_below ? 2'd2 : 2'd1;
                    o_dec.cmd0 = ttci_pkg::f_window(ttci_pkg::OP_SCROLL_UP, i_attr, w_row5,
                                                    i_col, w_row5, i_cfg.max_column, 1'b0);
                    o_dec.cmd1 = ttci_pkg::f_window(ttci_pkg::OP_SCROLL_UP, i_attr,
                                                    w_row5_next, 7'd0, LastRow5,
                                                    i_cfg.max_column, 1'b0);
                end
                ttci_pkg::CODE_INSERT_LINE: begin
                    o_col       = 7'd0;
                    o_dec.count = 2'd2;
                    if (w_row_below) begin
                        o_dec.cmd0 = ttci_pkg::f_window(ttci_pkg::OP_SCROLL_DOWN, i_attr,
                                                        w_row5, 7'd0, LastRow5,
                                                        i_cfg.max_column, 1'b1);
                        o_dec.cmd1 = ttci_pkg::f_cursor(w_row5, 7'd0);
                    end else begin
                        // On the bottom row the line is blanked after the cursor move.
                        o_dec.cmd0 = ttci_pkg::f_cursor(w_row5, 7'd0);
                        o_dec.cmd1 = ttci_pkg::f_window(ttci_pkg::OP_SCROLL_UP, i_attr,
                                                        w_row5, 7'd0, w_row5,
                                                        i_cfg.max_column, 1'b0);
                    end
                end
                ttci_pkg::CODE_ATTR_BLUE: begin
                    o_attr = (i_attr & ttci_pkg::ATTR_KEEP_MASK) | ttci_pkg::ATTR_BLUE;
                end
                ttci_pkg::CODE_ATTR_NORMAL, ttci_pkg::CODE_ATTR_PLAIN: begin
                    o_attr = (i_attr & ttci_pkg::ATTR_KEEP_MASK) | ttci_pkg::ATTR_WHITE;
                end
                ttci_pkg::CODE_DELETE_LINE: begin
                    o_col       = 7'd0;
                    o_dec.count = 2'd2;
                    o_dec.cmd0 = ttci_pkg::f_window(ttci_pkg::OP_SCROLL_UP, i_attr, w_row5,
                                                    7'd0, LastRow5, i_cfg.max_column, 1'b1);
                    o_dec.cmd1 = ttci_pkg::f_cursor(w_row5, 7'd0);
                end
                ttci_pkg::CODE_BELL: begin
                    o_dec.count   = 2'd1;
                    o_dec.cmd0    = '0;
                    o_dec.cmd0.op = ttci_pkg::OP_BELL;
                end
                ttci_pkg::CODE_BACKSPACE: begin
                    if (i_col != 7'd0) begin
                        o_col       = i_col - 7'd1;
                        o_dec.count = 2'd1;
                        o_dec.cmd0  = ttci_pkg::f_cursor(w_row5, i_col - 7'd1);
                    end
                end
                ttci_pkg::CODE_LINE_FEED: begin
                    o_dec.count = 2'd1;
                    if (w_row_below) begin
                        o_row      = i_row + 1'b1;
                        o_dec.cmd0 = ttci_pkg::f_cursor(w_row5_next, i_col);
                    end else begin
                        o_dec.cmd0 = ttci_pkg::f_window(ttci_pkg::OP_SCROLL_UP, i_attr, 5'd0,
                                                        7'd0, LastRow5, i_cfg.max_column,
                                                        1'b1);
                    end
                end
                ttci_pkg::CODE_BRIGHT_ON: begin
                    o_attr = i_attr | ttci_pkg::ATTR_BRIGHT;
                end
                ttci_pkg::CODE_BRIGHT_OFF: begin
                    o_attr = i_attr & ttci_pkg::ATTR_NOT_BRIGHT;
                end
                ttci_pkg::CODE_RETURN: begin
                    o_col = 7'd0;
                    if (i_col < i_cfg.max_column) begin
                        o_dec.count = 2'd2;
                        o_dec.cmd0 = ttci_pkg::f_window(ttci_pkg::OP_SCROLL_UP, i_attr,
                                                        w_row5, i_col, w_row5,
                                                        i_cfg.max_column, 1'b0);
                        o_dec.cmd1 = ttci_pkg::f_cursor(w_row5, 7'd0);
                    end else begin
                        o_dec.count = 2'd1;
                        o_dec.cmd0  = ttci_pkg::f_cursor(w_row5, 7'd0);
                    end
                end
                ttci_pkg::CODE_BLINK_OFF: begin
                    o_attr = i_attr & ttci_pkg::ATTR_NOT_BLINK;
                end
                ttci_pkg::CODE_REVERSE: begin
                    o_attr = (i_attr & ttci_pkg::ATTR_KEEP_MASK) | ttci_pkg::ATTR_REVERSE;
                end
                ttci_pkg::CODE_BLINK_ON: begin
                    o_attr = i_attr | ttci_pkg::ATTR_BLINK;
                end
                ttci_pkg::CODE_ADDRESS: begin
                    o_esc = ttci_pkg::ESC_ROW;
                end
                ttci_pkg::CODE_SHAPE_ALT: begin
                    o_dec.count   = 2'd1;
                    o_dec.cmd0    = '0;
                    o_dec.cmd0.op = ttci_pkg::OP_SHAPE;
                    o_dec.cmd0.cursor_shape = i_cfg.color_display ?
                        ttci_pkg::SHAPE_COLOR_ALT : ttci_pkg::SHAPE_MONO_ALT;
                end
                default: begin
                    o_dec.count   = 2'd1;
                    o_dec.cmd0    = '0;
                    o_dec.cmd0.op = ttci_pkg::OP_SHAPE;
                    o_dec.cmd0.cursor_shape = i_cfg.color_display ?
                        ttci_pkg::SHAPE_COLOR_NORMAL : ttci_pkg::SHAPE_MONO_NORMAL;
                end
            endcase
        end
    end

endmodule

// File: src/ttci_out_buf.sv
// Two-slot result register that holds the commands of one byte until the sink takes them.
`timescale 1ns / 1ps

module ttci_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  ttci_pkg::t_dec i_dec,
    input  logic           i_m_tready,
    output logic           o_ready,
    output logic           o_m_tvalid,
    output ttci_pkg::t_cmd o_cmd,
    output logic           o_m_tlast
);

    logic [1:0]     r_count;
    logic [1:0]     n_count;
    ttci_pkg::t_cmd r_slot0;
    ttci_pkg::t_cmd n_slot0;
    ttci_pkg::t_cmd r_slot1;
    ttci_pkg::t_cmd n_slot1;
    logic           r_last0;
    logic           n_last0;
    logic           w_pop;

    assign w_pop = (r_count != 2'd0) && i_m_tready;
    // A new byte may enter once the slots are empty by the end of this cycle.
    assign o_ready = (r_count == 2'd0) || ((r_count == 2'd1) && i_m_tready);

    always_comb begin
        n_count = r_count;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        n_last0 = r_last0;
        if (i_load) begin
            n_count = i_dec.count;
            n_slot0 = i_dec.cmd0;
            n_slot1 = i_dec.cmd1;
            n_last0 = (i_dec.count == 2'd1);
        end else if (w_pop) begin
            n_count = r_count - 2'd1;
            n_slot0 = r_slot1;
            n_last0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
        r_last0 <= n_last0;
    end

    assign o_m_tvalid = (r_count != 2'd0);
    assign o_cmd      = r_slot0;
    assign o_m_tlast  = r_last0;

endmodule

// File: src/text_terminal_control_interpreter.sv
// Top level of the terminal control interpreter: state, configuration and stream ports.
//
//  Channel | Direction | Beat contents
//  s       | in        | tdata[7:0] code
//  m       | out       | tdata op, char_code, attribute, row, col, bottom_row, right_col,
//          |           | line_count, cursor_shape (from bit 0 up); tlast last
//  cfg     | in        | i_cfg_we, i_cfg_index (0 max_column, 1 color_display), i_cfg_data
//
// A byte is decoded in the cycle it is accepted and its commands sit in the result
// register on the next cycle. A byte with one or no command may follow every cycle while
// the sink takes each command; one with two commands holds the input until the second drains.
// Reset is synchronous; it clears cursor, escape state and result slots and sets attribute 07h.
// A stalled sink stops the input as soon as the result slots cannot empty in time.
`timescale 1ns / 1ps

module text_terminal_control_interpreter #(
    parameter int LAST_ROW = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] code
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [2:0] op, [10:3] char_code, [18:11] attribute, [23:19] row, [30:24] col,
    // [35:31] bottom_row, [42:36] right_col, [43] line_count, [59:44] cursor_shape
    output logic [63:0] o_m_tdata,
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);

    localparam int ROW_W = $clog2(LAST_ROW + 1);

    ttci_pkg::t_cfg   r_cfg;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] n_row;
    logic [6:0]       r_col;
    logic [6:0]       n_col;
    logic [7:0]       r_attr;
    logic [7:0]       n_attr;
    ttci_pkg::t_esc   r_esc;
    ttci_pkg::t_esc   n_esc;
    logic [7:0]       r_pending;
    logic [7:0]       n_pending;
    ttci_pkg::t_dec   w_dec;
    ttci_pkg::t_cmd   w_cmd;
    logic             w_ready;
    logic             w_accept;

    assign o_s_tready = w_ready;
    assign w_accept   = i_s_tvalid && w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_column    <= ttci_pkg::MAX_COLUMN_RESET;
            r_cfg.color_display <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ttci_pkg::CFG_MAX_COLUMN:    r_cfg.max_column    <= i_cfg_data;
                ttci_pkg::CFG_COLOR_DISPLAY: r_cfg.color_display <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ttci_decode #(
        .LAST_ROW (LAST_ROW),
        .ROW_W    (ROW_W)
    ) u_decode (
        .i_code    (i_s_tdata),
        .i_cfg     (r_cfg),
        .i_row     (r_row),
        .i_col     (r_col),
        .i_attr    (r_attr),
        .i_esc     (r_esc),
        .i_pending (r_pending),
        .o_row     (n_row),
        .o_col     (n_col),
        .o_attr    (n_attr),
        .o_esc     (n_esc),
        .o_pending (n_pending),
        .o_dec     (w_dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_col     <= 7'd0;
            r_attr    <= ttci_pkg::ATTR_RESET;
            r_esc     <= ttci_pkg::ESC_IDLE;
            r_pending <= 8'd0;
        end else if (w_accept) begin
            r_row     <= n_row;
            r_col     <= n_col;
            r_attr    <= n_attr;
            r_esc     <= n_esc;
            r_pending <= n_pending;
        end
    end

    ttci_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_accept),
        .i_dec      (w_dec),
        .i_m_tready (i_m_tready),
        .o_ready    (w_ready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_m_tdata = {4'd0, w_cmd.cursor_shape, w_cmd.line_count, w_cmd.right_col,
                        w_cmd.bottom_row, w_cmd.col, w_cmd.row, w_cmd.attribute,
                        w_cmd.char_code, w_cmd.op};

endmodule

// File: src/ttci_checker.sv
// Port checker for the terminal control interpreter, bound to the top level.
`timescale 1ns / 1ps

module ttci_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic        o_m_tlast
);

    // A stalled result beat keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast)))
        else $error("result beat changed while stalled");

    a_op_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[2:0] <= 3'd5))
        else $error("command code out of range");

    // The second command of a byte is already waiting behind the first.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> o_m_tvalid)
        else $error("second command of a byte missing");

    // No new byte enters while the first of a pair is still shown.
    a_pair_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input accepted with two commands pending");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[63:60] == 4'd0))
        else $error("padding bits of result beat not zero");

endmodule

bind text_terminal_control_interpreter ttci_checker u_ttci_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
